// ===== hdl/rmig_pkg.sv =====
// Shared types and constants for the revolution mesh index generator.
package rmig_pkg;

    // Field and register widths
    localparam int VERT_W = 17;
    localparam int CFG_W  = 9;
    localparam int CNT_W  = 8;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Hard limits on the effective counts
    localparam int SEC_CAP  = 256;
    localparam int RING_CAP = 256;
    localparam logic [CFG_W-1:0] MIN_SECTIONS    = 9'd3;
    localparam logic [CFG_W-1:0] MIN_RING_POINTS = 9'd1;

    // Parameter defaults
    localparam int MAX_SECTIONS_DEF    = 256;
    localparam int MAX_RING_POINTS_DEF = 256;

    // Register reset values
    localparam logic [CFG_W-1:0] SECTIONS_RST    = 9'd8;
    localparam logic [CFG_W-1:0] RING_POINTS_RST = 9'd8;

    // Register index, taken from paddr[2]
    typedef enum logic [0:0] {
        CFG_SECTIONS    = 1'b0,
        CFG_RING_POINTS = 1'b1
    } cfg_idx_t;

    // Mesh region of a triangle
    typedef enum logic [1:0] {
        REGION_TOP  = 2'd0,
        REGION_MID  = 2'd1,
        REGION_SEAM = 2'd2,
        REGION_BOT  = 2'd3
    } region_t;

endpackage

// ===== hdl/revolution_mesh_index_generator_top.sv =====
// The triangle word is registered: it appears in the cycle after its request word is accepted.
// Throughput: one triangle per cycle while tri_ready is high; the output refills as it drains.
// The sequencer state and the clamp/multiply on the config registers set the single-cycle path.
// Reset (rst_n low, async): sections and ring_points return to 8, the sequence restarts at the
// first top-fan triangle and the output register is emptied.
// Any register write also restarts the sequence.
module revolution_mesh_index_generator_top #(
    parameter int MAX_SECTIONS    = rmig_pkg::MAX_SECTIONS_DEF,
    parameter int MAX_RING_POINTS = rmig_pkg::MAX_RING_POINTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rmig_pkg::ADDR_W-1:0]  paddr,
    input  logic [rmig_pkg::DATA_W-1:0]  pwdata,
    output logic [rmig_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // request channel
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         restart,
    // triangle channel
    output logic                         tri_valid,
    input  logic                         tri_ready,
    output logic [rmig_pkg::VERT_W-1:0]  vert_a,
    output logic [rmig_pkg::VERT_W-1:0]  vert_b,
    output logic [rmig_pkg::VERT_W-1:0]  vert_c,
    output logic [1:0]                   region,
    output logic                         last
);

    localparam int VW = rmig_pkg::VERT_W;
    localparam int CW = rmig_pkg::CFG_W;
    localparam int NW = rmig_pkg::CNT_W;

    localparam int SEC_HI  = (MAX_SECTIONS < rmig_pkg::SEC_CAP) ?
                             MAX_SECTIONS : rmig_pkg::SEC_CAP;
    localparam int RING_HI = (MAX_RING_POINTS < rmig_pkg::RING_CAP) ?
                             MAX_RING_POINTS : rmig_pkg::RING_CAP;
    localparam logic [CW-1:0] SEC_HI_V  = CW'(SEC_HI);
    localparam logic [CW-1:0] RING_HI_V = CW'(RING_HI);

    // Config registers
    logic [CW-1:0] sections_reg;
    logic [CW-1:0] ring_points_reg;

    // Sequencer state
    rmig_pkg::region_t phase_reg,  phase_next;
    logic [NW-1:0]     sec_cnt_reg, sec_cnt_next;
    logic [NW-1:0]     ring_cnt_reg, ring_cnt_next;
    logic              half_reg,   half_next;
    logic [VW-1:0]     base_reg,   base_next;

    // Output register
    logic              tri_valid_reg;
    logic [VW-1:0]     vert_a_reg, vert_a_next;
    logic [VW-1:0]     vert_b_reg, vert_b_next;
    logic [VW-1:0]     vert_c_reg, vert_c_next;
    rmig_pkg::region_t region_reg;
    logic              last_reg,   last_next;

    logic              cfg_wr;
    logic              accept;
    logic [CW-1:0]     s_eff;
    logic [CW-1:0]     m_eff;
    logic [CW-1:0]     s_m1;
    logic [2*CW-1:0]   prod;
    logic [VW-1:0]     vert_end;
    logic [VW-1:0]     m17;

    rmig_pkg::region_t cur_phase;
    logic [NW-1:0]     cur_sec;
    logic [NW-1:0]     cur_ring;
    logic              cur_half;
    logic [VW-1:0]     cur_base;
    logic [CW-1:0]     sec_inc;
    logic [CW-1:0]     ring_inc;
    logic [VW-1:0]     k17;
    logic [VW-1:0]     base_pm;
    logic              is_last_sec;

    assign cfg_wr     = psel & penable & pwrite & pready;
    assign pready     = 1'b1;
    assign item_ready = ~tri_valid_reg | tri_ready;
    assign accept     = item_valid & item_ready;

    // Register read
    always_comb
    begin
        case (rmig_pkg::cfg_idx_t'(paddr[2]))
            rmig_pkg::CFG_SECTIONS:    prdata = rmig_pkg::DATA_W'(sections_reg);
            rmig_pkg::CFG_RING_POINTS: prdata = rmig_pkg::DATA_W'(ring_points_reg);
            default:                   prdata = '0;
        endcase
    end

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sections_reg    <= rmig_pkg::SECTIONS_RST;
            ring_points_reg <= rmig_pkg::RING_POINTS_RST;
        end
        else if (cfg_wr)
        begin
            case (rmig_pkg::cfg_idx_t'(paddr[2]))
                rmig_pkg::CFG_SECTIONS:    sections_reg    <= pwdata[CW-1:0];
                rmig_pkg::CFG_RING_POINTS: ring_points_reg <= pwdata[CW-1:0];
                default:                   ;
            endcase
        end
    end

    // Clamp counts and derive the bottom pole index
    always_comb
    begin
        if (sections_reg > SEC_HI_V)
            s_eff = SEC_HI_V;
        else if (sections_reg < rmig_pkg::MIN_SECTIONS)
            s_eff = rmig_pkg::MIN_SECTIONS;
        else
            s_eff = sections_reg;

        if (ring_points_reg > RING_HI_V)
            m_eff = RING_HI_V;
        else if (ring_points_reg < rmig_pkg::MIN_RING_POINTS)
            m_eff = rmig_pkg::MIN_RING_POINTS;
        else
            m_eff = ring_points_reg;
    end

    assign s_m1     = s_eff - 1'b1;
    assign prod     = s_eff * m_eff;
    assign vert_end = VW'(prod) + VW'(1);
    assign m17      = VW'(m_eff);

    // Current state, with restart folded in
    assign cur_phase   = restart ? rmig_pkg::REGION_TOP : phase_reg;
    assign cur_sec     = restart ? '0 : sec_cnt_reg;
    assign cur_ring    = restart ? '0 : ring_cnt_reg;
    assign cur_half    = restart ? 1'b0 : half_reg;
    assign cur_base    = restart ? '0 : base_reg;
    assign sec_inc     = {1'b0, cur_sec} + 1'b1;
    assign ring_inc    = {1'b0, cur_ring} + 1'b1;
    assign k17         = VW'(cur_ring);
    assign base_pm     = cur_base + m17;
    assign is_last_sec = ({1'b0, cur_sec} == s_m1);

    // Triangle indices and next sequencer state
    always_comb
    begin
        phase_next    = cur_phase;
        sec_cnt_next  = cur_sec;
        ring_cnt_next = cur_ring;
        half_next     = cur_half;
        base_next     = cur_base;
        vert_a_next   = '0;
        vert_b_next   = '0;
        vert_c_next   = '0;
        last_next     = 1'b0;

        case (cur_phase)
            rmig_pkg::REGION_TOP:
            begin
                vert_a_next  = '0;
                vert_b_next  = is_last_sec ? VW'(1) : base_pm + VW'(1);
                vert_c_next  = cur_base + VW'(1);
                sec_cnt_next = sec_inc[NW-1:0];
                base_next    = base_pm;
                if (sec_inc >= s_eff)
                begin
                    sec_cnt_next  = '0;
                    base_next     = '0;
                    half_next     = 1'b0;
                    if (m_eff >= CW'(2))
                    begin
                        ring_cnt_next = NW'(1);
                        phase_next    = rmig_pkg::REGION_MID;
                    end
                    else
                    begin
                        ring_cnt_next = '0;
                        phase_next    = rmig_pkg::REGION_BOT;
                    end
                end
            end
            rmig_pkg::REGION_MID:
            begin
                vert_a_next = cur_base + k17;
                if (!cur_half)
                begin
                    vert_b_next = base_pm + k17 + VW'(1);
                    vert_c_next = cur_base + k17 + VW'(1);
                    half_next   = 1'b1;
                end
                else
                begin
                    vert_b_next   = base_pm + k17;
                    vert_c_next   = base_pm + k17 + VW'(1);
                    half_next     = 1'b0;
                    ring_cnt_next = ring_inc[NW-1:0];
                    if (ring_inc >= m_eff)
                    begin
                        ring_cnt_next = NW'(1);
                        sec_cnt_next  = sec_inc[NW-1:0];
                        base_next     = base_pm;
                        if (sec_inc >= s_m1)
                        begin
                            ring_cnt_next = '0;
                            phase_next    = rmig_pkg::REGION_SEAM;
                        end
                    end
                end
            end
            rmig_pkg::REGION_SEAM:
            begin
                // base holds the first vertex row of the last section here
                vert_a_next = cur_base + k17 + VW'(1);
                if (!cur_half)
                begin
                    vert_b_next = k17 + VW'(2);
                    vert_c_next = cur_base + k17 + VW'(2);
                    half_next   = 1'b1;
                end
                else
                begin
                    vert_b_next   = k17 + VW'(1);
                    vert_c_next   = k17 + VW'(2);
                    half_next     = 1'b0;
                    ring_cnt_next = ring_inc[NW-1:0];
                    if (({1'b0, ring_inc} + 1'b1) >= {1'b0, m_eff})
                    begin
                        ring_cnt_next = '0;
                        sec_cnt_next  = '0;
                        base_next     = '0;
                        phase_next    = rmig_pkg::REGION_BOT;
                    end
                end
            end
            rmig_pkg::REGION_BOT:
            begin
                vert_a_next = base_pm;
                vert_b_next = is_last_sec ? m17 : base_pm + m17;
                vert_c_next = vert_end;
                if ({1'b0, cur_sec} >= s_m1)
                begin
                    last_next     = 1'b1;
                    phase_next    = rmig_pkg::REGION_TOP;
                    sec_cnt_next  = '0;
                    ring_cnt_next = '0;
                    half_next     = 1'b0;
                    base_next     = '0;
                end
                else
                begin
                    sec_cnt_next = sec_inc[NW-1:0];
                    base_next    = base_pm;
                end
            end
            default:
            begin
                phase_next = rmig_pkg::REGION_TOP;
            end
        endcase
    end

    // Sequencer state register; a config write restarts the mesh
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rmig_pkg::REGION_TOP;
            sec_cnt_reg  <= '0;
            ring_cnt_reg <= '0;
            half_reg     <= 1'b0;
            base_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            phase_reg    <= rmig_pkg::REGION_TOP;
            sec_cnt_reg  <= '0;
            ring_cnt_reg <= '0;
            half_reg     <= 1'b0;
            base_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            sec_cnt_reg  <= sec_cnt_next;
            ring_cnt_reg <= ring_cnt_next;
            half_reg     <= half_next;
            base_reg     <= base_next;
        end
    end

    // Output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tri_valid_reg <= 1'b0;
        else if (accept)
            tri_valid_reg <= 1'b1;
        else if (tri_ready)
            tri_valid_reg <= 1'b0;
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vert_a_reg <= vert_a_next;
            vert_b_reg <= vert_b_next;
            vert_c_reg <= vert_c_next;
            region_reg <= cur_phase;
            last_reg   <= last_next;
        end
    end

    assign tri_valid = tri_valid_reg;
    assign vert_a    = vert_a_reg;
    assign vert_b    = vert_b_reg;
    assign vert_c    = vert_c_reg;
    assign region    = region_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/rmig_checker.sv =====
// Port-level checker for the revolution mesh index generator, bound to the top level.
module rmig_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic                        tri_valid,
    input logic                        tri_ready,
    input logic [rmig_pkg::VERT_W-1:0] vert_a,
    input logic [rmig_pkg::VERT_W-1:0] vert_b,
    input logic [rmig_pkg::VERT_W-1:0] vert_c,
    input logic [1:0]                  region,
    input logic                        last
);

    // A stalled output word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tri_valid && !tri_ready |=> tri_valid && $stable(vert_a) && $stable(vert_b)
                                    && $stable(vert_c) && $stable(region) && $stable(last))
        else $error("stalled triangle word changed");

    // Every accepted request yields a word in the next cycle
    a_resp: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> tri_valid)
        else $error("accepted request gave no triangle");

    // The final triangle is always a bottom-fan triangle
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        tri_valid && last |-> region == rmig_pkg::REGION_BOT)
        else $error("last flag outside bottom fan");

    // Top fan triangles start at the top pole
    a_top: assert property (@(posedge clk) disable iff (!rst_n)
        tri_valid && region == rmig_pkg::REGION_TOP |-> vert_a == '0 && !last)
        else $error("top fan triangle does not use the top pole");

    // Bottom fan triangles end at the bottom pole, above every ring vertex
    a_bot: assert property (@(posedge clk) disable iff (!rst_n)
        tri_valid && region == rmig_pkg::REGION_BOT |-> vert_c > vert_a && vert_c > vert_b)
        else $error("bottom fan triangle does not end at the bottom pole");

endmodule

bind revolution_mesh_index_generator_top rmig_checker u_rmig_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .tri_valid  (tri_valid),
    .tri_ready  (tri_ready),
    .vert_a     (vert_a),
    .vert_b     (vert_b),
    .vert_c     (vert_c),
    .region     (region),
    .last       (last)
);

// ===== sim/tb_revolution_mesh_index_generator_top.sv =====
`timescale 1ns / 1ps
// Testbench for the revolution mesh index generator: directed table, then random meshes.
module tb_revolution_mesh_index_generator_top;

    // Effective count limits for the default parameters
    localparam int SEC_LIM  = (rmig_pkg::SEC_CAP < rmig_pkg::MAX_SECTIONS_DEF) ?
                              rmig_pkg::SEC_CAP : rmig_pkg::MAX_SECTIONS_DEF;
    localparam int RING_LIM = (rmig_pkg::RING_CAP < rmig_pkg::MAX_RING_POINTS_DEF) ?
                              rmig_pkg::RING_CAP : rmig_pkg::MAX_RING_POINTS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTS  = 200;

    // Short names for the table below
    localparam rmig_pkg::cfg_idx_t C_SEC  = rmig_pkg::CFG_SECTIONS;
    localparam rmig_pkg::cfg_idx_t C_RING = rmig_pkg::CFG_RING_POINTS;
    localparam rmig_pkg::region_t  R_TOP  = rmig_pkg::REGION_TOP;
    localparam rmig_pkg::region_t  R_BOT  = rmig_pkg::REGION_BOT;

    typedef struct packed {
        logic [rmig_pkg::VERT_W-1:0] va;
        logic [rmig_pkg::VERT_W-1:0] vb;
        logic [rmig_pkg::VERT_W-1:0] vc;
        rmig_pkg::region_t           rgn;
        logic                        fin;
    } tri_t;

    typedef enum logic {
        ROW_WORD = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        rmig_pkg::cfg_idx_t          idx;
        logic [rmig_pkg::DATA_W-1:0] val;
        logic                        rs;
        logic                        typed;
        tri_t                        want;
    } dir_row_t;

    localparam tri_t NO_TRI = '0;
    localparam int   DIR_N  = 24;

    // Directed table: typed triangles only where they are obvious
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b1, '{17'd0, 17'd9, 17'd1, R_TOP, 1'b0}},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b0, NO_TRI},
        '{ROW_WORD, C_SEC, 32'h0, 1'b1, 1'b1, '{17'd0, 17'd9, 17'd1, R_TOP, 1'b0}},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b0, NO_TRI},
        '{ROW_CFG, C_SEC, 32'hFFFF_FE03, 1'b0, 1'b0, NO_TRI},
        '{ROW_CFG, C_RING, 32'h5555_5401, 1'b0, 1'b0, NO_TRI},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b1, '{17'd0, 17'd2, 17'd1, R_TOP, 1'b0}},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b1, '{17'd0, 17'd3, 17'd2, R_TOP, 1'b0}},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b1, '{17'd0, 17'd1, 17'd3, R_TOP, 1'b0}},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b1, '{17'd1, 17'd2, 17'd4, R_BOT, 1'b0}},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b1, '{17'd2, 17'd3, 17'd4, R_BOT, 1'b0}},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b1, '{17'd3, 17'd1, 17'd4, R_BOT, 1'b1}},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b1, '{17'd0, 17'd2, 17'd1, R_TOP, 1'b0}},
        '{ROW_CFG, C_SEC, 32'h0000_0000, 1'b0, 1'b0, NO_TRI},
        '{ROW_CFG, C_RING, 32'h0000_0000, 1'b0, 1'b0, NO_TRI},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b1, '{17'd0, 17'd2, 17'd1, R_TOP, 1'b0}},
        '{ROW_WORD, C_SEC, 32'h0, 1'b1, 1'b1, '{17'd0, 17'd2, 17'd1, R_TOP, 1'b0}},
        '{ROW_CFG, C_SEC, 32'h0000_01FF, 1'b0, 1'b0, NO_TRI},
        '{ROW_CFG, C_RING, 32'hAAAA_A3FF, 1'b0, 1'b0, NO_TRI},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b1, '{17'd0, 17'd257, 17'd1, R_TOP, 1'b0}},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b0, NO_TRI},
        '{ROW_CFG, C_RING, 32'h0000_0002, 1'b0, 1'b0, NO_TRI},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b0, NO_TRI},
        '{ROW_WORD, C_SEC, 32'h0, 1'b0, 1'b0, NO_TRI}
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [rmig_pkg::ADDR_W-1:0]  paddr = '0;
    logic [rmig_pkg::DATA_W-1:0]  pwdata = '0;
    logic [rmig_pkg::DATA_W-1:0]  prdata;
    logic                         pready;
    logic                         item_valid = 1'b0;
    logic                         item_ready;
    logic                         restart = 1'b0;
    logic                         tri_valid;
    logic                         tri_ready = 1'b0;
    logic [rmig_pkg::VERT_W-1:0]  vert_a;
    logic [rmig_pkg::VERT_W-1:0]  vert_b;
    logic [rmig_pkg::VERT_W-1:0]  vert_c;
    logic [1:0]                   region;
    logic                         last;

    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 55;
    int unsigned err_count = 0;
    int unsigned quiet_cycles = 0;

    // Triangles still owed by the block, oldest first
    tri_t tri_queue[$];

    // Shadow of the registers and of the mesh walk
    logic [rmig_pkg::CFG_W-1:0] cfg_sec = rmig_pkg::SECTIONS_RST;
    logic [rmig_pkg::CFG_W-1:0] cfg_ring = rmig_pkg::RING_POINTS_RST;
    rmig_pkg::region_t          mesh_phase = rmig_pkg::REGION_TOP;
    int unsigned                mesh_sec = 0;
    int unsigned                mesh_ring = 0;
    int unsigned                mesh_base = 0;
    logic                       mesh_odd = 1'b0;

    revolution_mesh_index_generator_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .restart    (restart),
        .tri_valid  (tri_valid),
        .tri_ready  (tri_ready),
        .vert_a     (vert_a),
        .vert_b     (vert_b),
        .vert_c     (vert_c),
        .region     (region),
        .last       (last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
        begin
            $display("%0d ns: %s", $time, msg);
        end
    endtask

    function automatic void restart_mesh();
        mesh_phase = rmig_pkg::REGION_TOP;
        mesh_sec   = 0;
        mesh_ring  = 0;
        mesh_base  = 0;
        mesh_odd   = 1'b0;
    endfunction

    // Next triangle of the mesh walk; advances the shadow state
    function automatic tri_t next_triangle(input logic rs);
        tri_t        t;
        int unsigned s, m, bs, k, a, b, c;
        s = int'(cfg_sec);
        m = int'(cfg_ring);
        if (s > SEC_LIM) s = SEC_LIM;
        if (s < int'(rmig_pkg::MIN_SECTIONS)) s = int'(rmig_pkg::MIN_SECTIONS);
        if (m > RING_LIM) m = RING_LIM;
        if (m < int'(rmig_pkg::MIN_RING_POINTS)) m = int'(rmig_pkg::MIN_RING_POINTS);
        t = '0;
        if (rs) restart_mesh();
        bs    = mesh_base;
        k     = mesh_ring;
        t.rgn = mesh_phase;
        case (mesh_phase)
            rmig_pkg::REGION_TOP:
            begin
                a = 0;
                b = (mesh_sec == s - 1) ? 1 : bs + m + 1;
                c = bs + 1;
                mesh_sec++;
                mesh_base = bs + m;
                if (mesh_sec >= s)
                begin
                    mesh_sec   = 0;
                    mesh_base  = 0;
                    mesh_ring  = (m >= 2) ? 1 : 0;
                    mesh_odd   = 1'b0;
                    mesh_phase = (m >= 2) ? rmig_pkg::REGION_MID : rmig_pkg::REGION_BOT;
                end
            end
            rmig_pkg::REGION_MID:
            begin
                a = bs + k;
                if (!mesh_odd)
                begin
                    b = bs + m + k + 1;
                    c = bs + k + 1;
                    mesh_odd = 1'b1;
                end
                else
                begin
                    b = bs + m + k;
                    c = bs + m + k + 1;
                    mesh_odd  = 1'b0;
                    mesh_ring = k + 1;
                    // quad column done: step to the next section
                    if (mesh_ring >= m)
                    begin
                        mesh_ring = 1;
                        mesh_sec++;
                        mesh_base = bs + m;
                        if (mesh_sec >= s - 1)
                        begin
                            mesh_ring  = 0;
                            mesh_phase = rmig_pkg::REGION_SEAM;
                        end
                    end
                end
            end
            rmig_pkg::REGION_SEAM:
            begin
                a = bs + k + 1;
                if (!mesh_odd)
                begin
                    b = k + 2;
                    c = bs + k + 2;
                    mesh_odd = 1'b1;
                end
                else
                begin
                    b = k + 1;
                    c = k + 2;
                    mesh_odd  = 1'b0;
                    mesh_ring = k + 1;
                    if (mesh_ring + 1 >= m)
                    begin
                        mesh_ring  = 0;
                        mesh_sec   = 0;
                        mesh_base  = 0;
                        mesh_phase = rmig_pkg::REGION_BOT;
                    end
                end
            end
            default:
            begin
                a = bs + m;
                b = (mesh_sec == s - 1) ? m : bs + 2 * m;
                c = s * m + 1;
                if (mesh_sec >= s - 1)
                begin
                    t.fin = 1'b1;
                    restart_mesh();
                end
                else
                begin
                    mesh_sec++;
                    mesh_base = bs + m;
                end
            end
        endcase
        t.va = rmig_pkg::VERT_W'(a);
        t.vb = rmig_pkg::VERT_W'(b);
        t.vc = rmig_pkg::VERT_W'(c);
        return t;
    endfunction

    // Offer one request word, with a random gap in front of it
    task automatic send_word(input logic rs, input logic typed, input tri_t typed_tri);
        tri_t t;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            restart    <= 1'($urandom_range(0, 1));
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        item_valid <= 1'b1;
        restart    <= rs;
        do @(posedge clk); while (!item_ready);
        t = next_triangle(rs);
        tri_queue.push_back(typed ? typed_tri : t);
    endtask

    // Wait for the block to go idle, then write a register and read it back
    task automatic apply_reg(input rmig_pkg::cfg_idx_t idx,
                             input logic [rmig_pkg::DATA_W-1:0] val);
        item_valid <= 1'b0;
        while (tri_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        // write: setup then access
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == rmig_pkg::CFG_SECTIONS) cfg_sec = val[rmig_pkg::CFG_W-1:0];
        else cfg_ring = val[rmig_pkg::CFG_W-1:0];
        restart_mesh();
        @(posedge clk);
        // read back
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== rmig_pkg::DATA_W'(val[rmig_pkg::CFG_W-1:0]))
        begin
            report_error($sformatf("register %s read 0x%0h, wrote 0x%0h",
                                   idx.name(), prdata, val));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Triangle checker and receiver stalls
    always @(posedge clk)
    begin : tri_check
        tri_t got;
        tri_t want;
        if (rst_n && tri_valid && tri_ready)
        begin
            got.va  = vert_a;
            got.vb  = vert_b;
            got.vc  = vert_c;
            got.rgn = rmig_pkg::region_t'(region);
            got.fin = last;
            if (tri_queue.size() == 0)
            begin
                report_error($sformatf("unrequested triangle (%0d,%0d,%0d) r%0d l%0d",
                                       got.va, got.vb, got.vc, got.rgn, got.fin));
            end
            else
            begin
                want = tri_queue.pop_front();
                if (got.va !== want.va || got.vb !== want.vb || got.vc !== want.vc ||
                    got.rgn !== want.rgn || got.fin !== want.fin)
                begin
                    report_error($sformatf(
                        "triangle (%0d,%0d,%0d) r%0d l%0d, want (%0d,%0d,%0d) r%0d l%0d",
                        got.va, got.vb, got.vc, got.rgn, got.fin,
                        want.va, want.vb, want.vc, want.rgn, want.fin));
                end
            end
        end
        tri_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (tri_valid && tri_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_revolution_mesh_index_generator_top: errors");
            $finish;
        end
    end

    initial
    begin
        int          mode;
        int unsigned n;
        int unsigned sv;
        int unsigned rv;
        logic [rmig_pkg::DATA_W-1:0] wv;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_N; r++)
        begin
            if (DIR_ROWS[r].kind == ROW_CFG)
                apply_reg(DIR_ROWS[r].idx, DIR_ROWS[r].val);
            else
                send_word(DIR_ROWS[r].rs, DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end

        // random meshes under three idle mixes
        for (mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 55 : 0;
            recv_idle_pct = (mode == 0) ? 55 : (mode == 1) ? 35 : 0;
            repeat (4)
            begin
                case ($urandom_range(0, 9))
                    0: sv = $urandom_range(0, 2);
                    1: sv = $urandom_range(257, 511);
                    2: sv = 256;
                    default: sv = $urandom_range(3, 6);
                endcase
                case ($urandom_range(0, 9))
                    0: rv = 0;
                    1: rv = $urandom_range(6, 20);
                    2: rv = $urandom_range(257, 511);
                    default: rv = $urandom_range(1, 5);
                endcase
                wv = $urandom();
                wv[rmig_pkg::CFG_W-1:0] = sv[rmig_pkg::CFG_W-1:0];
                apply_reg(rmig_pkg::CFG_SECTIONS, wv);
                wv = $urandom();
                wv[rmig_pkg::CFG_W-1:0] = rv[rmig_pkg::CFG_W-1:0];
                apply_reg(rmig_pkg::CFG_RING_POINTS, wv);
                n = $urandom_range(60, 110);
                repeat (n) send_word($urandom_range(0, 99) < 3, 1'b0, NO_TRI);
            end
        end

        // drain
        item_valid <= 1'b0;
        while (tri_queue.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (err_count == 0)
            $display("tb_revolution_mesh_index_generator_top: clean");
        else
            $display("tb_revolution_mesh_index_generator_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rmig_pkg.sv
hdl/revolution_mesh_index_generator_top.sv
hdl/rmig_checker.sv
sim/tb_revolution_mesh_index_generator_top.sv
